FILE: rtl/ljac_pkg.sv
// Shared types and constants for the landmark observation Jacobian unit.
// No dependencies; imported by ljac_cordic and landmark_observation_jacobian_unit.

package ljac_pkg;

    // Number of CORDIC rotations, one per pipeline stage.
    localparam int CORDIC_STEPS = 20;

    // Width of the CORDIC datapath in Q30 (x, y and angle).
    localparam int CORDIC_W = 34;

    // Width used to compare a column against the state length.
    localparam int COL_CMP_W = 13;

    // Lowest column that a landmark may occupy.
    localparam logic [7:0] MIN_COLUMN = 8'd3;

    // Angle constants in Q30 radians.
    localparam logic signed [CORDIC_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // Start vector length, the inverse CORDIC gain in Q30.
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Truncated arctangent of 2^-k in Q30.
    localparam logic [31:0] CORDIC_ATAN [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF
    };

    // Stages inside the CORDIC block: rotations, sign flip, rounding.
    localparam int CORDIC_LATENCY = CORDIC_STEPS + 2;

    // Request data that rides alongside the trig pipeline.
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [7:0]         column;
        logic               last;
    } side_t;

endpackage

FILE: rtl/ljac_cordic.sv
// Pipelined rotation-mode CORDIC giving rounded Q1.15 cos and sin of a Q30 angle.
// Depends on ljac_pkg for the arctangent table, widths and the side_t struct.

module ljac_cordic
    import ljac_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [CORDIC_W-1:0] in_angle,
    input  logic                       in_flip,
    input  side_t                      in_side,
    output logic                       out_valid,
    output logic signed [15:0]         out_cos,
    output logic signed [15:0]         out_sin,
    output side_t                      out_side
);

    // One register set per rotation stage.
    logic                       valid_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] x_reg     [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg     [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_reg     [CORDIC_STEPS];
    logic                       flip_reg  [CORDIC_STEPS];
    side_t                      side_reg  [CORDIC_STEPS];

    logic signed [CORDIC_W-1:0] x_next [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_next [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_next [CORDIC_STEPS];

    // Sign flip stage and rounding stage.
    logic                     neg_valid_reg;
    logic signed [CORDIC_W:0] xn_reg;
    logic signed [CORDIC_W:0] yn_reg;
    side_t                    neg_side_reg;
    logic signed [CORDIC_W:0] xn_next;
    logic signed [CORDIC_W:0] yn_next;

    logic                     rnd_valid_reg;
    logic signed [15:0]       cos_reg;
    logic signed [15:0]       sin_reg;
    side_t                    rnd_side_reg;
    logic signed [15:0]       cos_next;
    logic signed [15:0]       sin_next;

    // Each stage rotates the vector of the stage before it by one table angle.
    always_comb
    begin
        logic signed [CORDIC_W-1:0] xp;
        logic signed [CORDIC_W-1:0] yp;
        logic signed [CORDIC_W-1:0] zp;
        logic signed [CORDIC_W-1:0] ang;
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            if (k == 0)
            begin
                xp = CORDIC_GAIN_Q30;
                yp = '0;
                zp = in_angle;
            end
            else
            begin
                xp = x_reg[k-1];
                yp = y_reg[k-1];
                zp = z_reg[k-1];
            end
            ang = $signed({2'b00, CORDIC_ATAN[k]});
            if (!zp[CORDIC_W-1])
            begin
                x_next[k] = xp - (yp >>> k);
                y_next[k] = yp + (xp >>> k);
                z_next[k] = zp - ang;
            end
            else
            begin
                x_next[k] = xp + (yp >>> k);
                y_next[k] = yp - (xp >>> k);
                z_next[k] = zp + ang;
            end
        end
    end

    // Valid bits of the rotation stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < CORDIC_STEPS; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Data of the rotation stages.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            x_reg[k] <= x_next[k];
            y_reg[k] <= y_next[k];
            z_reg[k] <= z_next[k];
        end
        flip_reg[0] <= in_flip;
        side_reg[0] <= in_side;
        for (int k = 1; k < CORDIC_STEPS; k++)
        begin
            flip_reg[k] <= flip_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    // Undo the half-turn fold by negating the vector.
    always_comb
    begin
        xn_next = (CORDIC_W+1)'(x_reg[CORDIC_STEPS-1]);
        yn_next = (CORDIC_W+1)'(y_reg[CORDIC_STEPS-1]);
        if (flip_reg[CORDIC_STEPS-1])
        begin
            xn_next = -xn_next;
            yn_next = -yn_next;
        end
    end

    // Round Q30 to Q15 and clip plus one to the largest code.
    function automatic logic signed [15:0] round_q15(input logic signed [CORDIC_W:0] v);
        logic signed [CORDIC_W:0] r;
        r = (v + (CORDIC_W+1)'(16384)) >>> 15;
        if (r > (CORDIC_W+1)'(32767))
        begin
            return 16'sd32767;
        end
        else if (r < -(CORDIC_W+1)'(32768))
        begin
            return -16'sd32768;
        end
        return r[15:0];
    endfunction

    assign cos_next = round_q15(xn_reg);
    assign sin_next = round_q15(yn_reg);

    // Valid bits of the flip and rounding stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_valid_reg <= 1'b0;
            rnd_valid_reg <= 1'b0;
        end
        else
        begin
            neg_valid_reg <= valid_reg[CORDIC_STEPS-1];
            rnd_valid_reg <= neg_valid_reg;
        end
    end

    // Data of the flip and rounding stages.
    always_ff @(posedge clk)
    begin
        xn_reg       <= xn_next;
        yn_reg       <= yn_next;
        neg_side_reg <= side_reg[CORDIC_STEPS-1];
        cos_reg      <= cos_next;
        sin_reg      <= sin_next;
        rnd_side_reg <= neg_side_reg;
    end

    assign out_valid = rnd_valid_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_side  = rnd_side_reg;

    // A result leaves exactly the pipeline depth after its request entered.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, CORDIC_LATENCY))
        else $error("CORDIC result without a matching request");

    // The rotation residue stays small, so no stage wraps the angle.
    a_residue: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[CORDIC_STEPS-1] |->
            (z_reg[CORDIC_STEPS-1] < 34'sd1048576 && z_reg[CORDIC_STEPS-1] > -34'sd1048576))
        else $error("CORDIC angle residue out of range");

endmodule

FILE: rtl/landmark_observation_jacobian_unit.sv
// Top level of the landmark observation Jacobian unit.
// Depends on ljac_pkg and instantiates the ljac_cordic trig pipeline.
//
// Usage: drive one matched landmark per request (pose, heading, landmark
// position, state column, last flag) and pulse start. busy is always low, so
// a request is taken on every cycle that start is high. Each request gives
// one result: cos and sin of the heading, the two heading derivatives of the
// landmark's Jacobian rows, the checked column and the last flag, shown for
// exactly one cycle with done high.
// Pipeline: one input stage, 20 CORDIC rotation stages, a flip and a rounding
// stage, then multiply, add and round stages for the derivatives.
// Throughput: one landmark per cycle, set by the fully pipelined CORDIC and
// the four 16 by 33 bit multipliers working in parallel.
// Reset clears every valid bit, so no result appears after reset until a new
// request has passed through. The receiver cannot stall; results stream out
// in request order.

module landmark_observation_jacobian_unit
    import ljac_pkg::*;
#(
    parameter int STATE_LENGTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] car_x,
    input  logic signed [31:0] car_y,
    input  logic signed [15:0] heading,
    input  logic signed [31:0] landmark_x,
    input  logic signed [31:0] landmark_y,
    input  logic [7:0]         landmark_column,
    input  logic               last_in,
    output logic               done,
    output logic signed [15:0] cos_heading,
    output logic signed [15:0] sin_heading,
    output logic signed [31:0] first_row_heading_deriv,
    output logic signed [31:0] second_row_heading_deriv,
    output logic [7:0]         column_out,
    output logic               last_out
);

    localparam logic [COL_CMP_W-1:0] STATE_LEN_CMP = COL_CMP_W'(STATE_LENGTH);
    localparam int TOTAL_LATENCY = CORDIC_LATENCY + 4;

    logic accept;

    // Input stage.
    logic                       in_valid_reg;
    logic signed [CORDIC_W-1:0] angle_reg;
    logic                       flip_reg;
    side_t                      side_reg;
    logic signed [CORDIC_W-1:0] angle_next;
    logic                       flip_next;
    side_t                      side_next;
    logic signed [CORDIC_W-1:0] angle_raw;

    // Trig pipeline outputs.
    logic               trig_valid;
    logic signed [15:0] trig_cos;
    logic signed [15:0] trig_sin;
    side_t              trig_side;

    // Product stage.
    logic               mul_valid_reg;
    logic signed [48:0] p_sdx_reg;
    logic signed [48:0] p_cdy_reg;
    logic signed [48:0] p_cdx_reg;
    logic signed [48:0] p_sdy_reg;
    logic signed [15:0] mul_cos_reg;
    logic signed [15:0] mul_sin_reg;
    logic [7:0]         mul_column_reg;
    logic               mul_last_reg;

    // Sum stage.
    logic               sum_valid_reg;
    logic signed [49:0] d1_reg;
    logic signed [49:0] d2_reg;
    logic signed [15:0] sum_cos_reg;
    logic signed [15:0] sum_sin_reg;
    logic [7:0]         sum_column_reg;
    logic               sum_last_reg;
    logic signed [49:0] d1_next;
    logic signed [49:0] d2_next;

    // Output stage.
    logic               out_valid_reg;
    logic signed [31:0] d1_out_reg;
    logic signed [31:0] d2_out_reg;
    logic signed [15:0] cos_out_reg;
    logic signed [15:0] sin_out_reg;
    logic [7:0]         column_out_reg;
    logic               last_out_reg;
    logic signed [31:0] d1_out_next;
    logic signed [31:0] d2_out_next;

    // The pipeline never stalls, so every request is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Scale heading to Q30 and fold it into the CORDIC range by a half turn.
    assign angle_raw = {heading[15], heading, 17'b0};

    always_comb
    begin
        angle_next = angle_raw;
        flip_next  = 1'b0;
        priority if (angle_raw > HALF_PI_Q30)
        begin
            angle_next = angle_raw - PI_Q30;
            flip_next  = 1'b1;
        end
        else if (angle_raw < -HALF_PI_Q30)
        begin
            angle_next = angle_raw + PI_Q30;
            flip_next  = 1'b1;
        end
        else
        begin
            angle_next = angle_raw;
            flip_next  = 1'b0;
        end
    end

    // Position differences and the column range check.
    always_comb
    begin
        side_next.dx   = 33'(landmark_x) - 33'(car_x);
        side_next.dy   = 33'(landmark_y) - 33'(car_y);
        side_next.last = last_in;
        if (landmark_column >= MIN_COLUMN &&
            (COL_CMP_W'(landmark_column) + COL_CMP_W'(1)) < STATE_LEN_CMP)
        begin
            side_next.column = landmark_column;
        end
        else
        begin
            side_next.column = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        flip_reg  <= flip_next;
        side_reg  <= side_next;
    end

    // Cos and sin of the heading.
    ljac_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_angle  (angle_reg),
        .in_flip   (flip_reg),
        .in_side   (side_reg),
        .out_valid (trig_valid),
        .out_cos   (trig_cos),
        .out_sin   (trig_sin),
        .out_side  (trig_side)
    );

    // Exact Q31 products of trig values and position differences.
    always_ff @(posedge clk)
    begin
        p_sdx_reg      <= 49'(trig_sin) * 49'($signed(trig_side.dx));
        p_cdy_reg      <= 49'(trig_cos) * 49'($signed(trig_side.dy));
        p_cdx_reg      <= 49'(trig_cos) * 49'($signed(trig_side.dx));
        p_sdy_reg      <= 49'(trig_sin) * 49'($signed(trig_side.dy));
        mul_cos_reg    <= trig_cos;
        mul_sin_reg    <= trig_sin;
        mul_column_reg <= trig_side.column;
        mul_last_reg   <= trig_side.last;
    end

    // Combine the products into the two heading derivatives.
    assign d1_next = 50'(p_cdy_reg) - 50'(p_sdx_reg);
    assign d2_next = -50'(p_cdx_reg) - 50'(p_sdy_reg);

    always_ff @(posedge clk)
    begin
        d1_reg         <= d1_next;
        d2_reg         <= d2_next;
        sum_cos_reg    <= mul_cos_reg;
        sum_sin_reg    <= mul_sin_reg;
        sum_column_reg <= mul_column_reg;
        sum_last_reg   <= mul_last_reg;
    end

    // Round Q31 to Q16.16 and clip to the 32 bit range.
    function automatic logic signed [31:0] round_sat32(input logic signed [49:0] v);
        logic signed [50:0] r;
        r = (51'(v) + 51'sd16384) >>> 15;
        if (r > 51'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (r < -51'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return r[31:0];
    endfunction

    assign d1_out_next = round_sat32(d1_reg);
    assign d2_out_next = round_sat32(d2_reg);

    always_ff @(posedge clk)
    begin
        d1_out_reg     <= d1_out_next;
        d2_out_reg     <= d2_out_next;
        cos_out_reg    <= sum_cos_reg;
        sin_out_reg    <= sum_sin_reg;
        column_out_reg <= sum_column_reg;
        last_out_reg   <= sum_last_reg;
    end

    // Valid bits of the derivative stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= trig_valid;
            sum_valid_reg <= mul_valid_reg;
            out_valid_reg <= sum_valid_reg;
        end
    end

    assign done                     = out_valid_reg;
    assign cos_heading              = cos_out_reg;
    assign sin_heading              = sin_out_reg;
    assign first_row_heading_deriv  = d1_out_reg;
    assign second_row_heading_deriv = d2_out_reg;
    assign column_out               = column_out_reg;
    assign last_out                 = last_out_reg;

    // Every result matches a request taken the full latency earlier.
    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, TOTAL_LATENCY))
        else $error("Result strobe without a matching request");

    // The last flag arrives with the result of the request that carried it.
    a_last_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (last_out == $past(last_in, TOTAL_LATENCY)))
        else $error("Last flag out of step with its request");

    // A placed column always lies inside the state vector.
    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (column_out == 8'd0 ||
                  (column_out >= MIN_COLUMN &&
                   (COL_CMP_W'(column_out) + COL_CMP_W'(1)) < STATE_LEN_CMP)))
        else $error("Placed column outside the state vector");

    // The column passes through unchanged when it is in range.
    a_column_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (done && column_out != 8'd0) |->
            (column_out == $past(landmark_column, TOTAL_LATENCY)))
        else $error("Column changed on its way through the pipeline");

endmodule
